FILE: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg - shared definitions for the gaussian blur stream unit
// Frame limits, kernel weight tables, divisor reciprocals and pipeline types.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 3;
    localparam int WIN        = 2 * MAX_RADIUS + 1;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int LINE_BITS  = 8 * LINES;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_KERNEL = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // kernel select codes
    localparam logic [1:0] KSEL_3X3 = 2'd0;
    localparam logic [1:0] KSEL_5X5 = 2'd1;
    localparam logic [1:0] KSEL_7X7 = 2'd2;

    // sum and reciprocal arithmetic
    localparam int SUM_W   = 18;
    localparam int RECIP_W = 25;
    localparam int RECIP_S = 28;
    localparam int MUL_W   = SUM_W + RECIP_W;

    typedef logic [7:0] pix_t;

    // weights placed in the bottom-right corner of the 7x7 window
    localparam logic [7:0] KERN [3][WIN][WIN] = '{
        '{ '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0},
           '{0,0,0,0,0,0,0}, '{0,0,0,0,1,2,1}, '{0,0,0,0,2,4,2},
           '{0,0,0,0,1,2,1} },
        '{ '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,1,4,7,4,1},
           '{0,0,4,16,26,16,4}, '{0,0,7,26,41,26,7}, '{0,0,4,16,26,16,4},
           '{0,0,1,4,7,4,1} },
        '{ '{0,0,1,2,1,0,0}, '{0,3,13,22,13,3,0}, '{1,13,59,97,59,13,1},
           '{2,22,97,159,97,22,2}, '{1,13,59,97,59,13,1},
           '{0,3,13,22,13,3,0}, '{0,0,1,2,1,0,0} }
    };

    // ceil(2^28 / total) for totals 16, 273 and 1003, exact over 18-bit sums
    function automatic logic [RECIP_W-1:0] recip(input logic [1:0] sel);
        logic [RECIP_W-1:0] m;
        begin
            case (sel)
                KSEL_3X3: m = RECIP_W'(16777216);
                KSEL_5X5: m = RECIP_W'(983281);
                default:  m = RECIP_W'(267633);
            endcase
            return m;
        end
    endfunction

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } line_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/gaussian_blur_stream_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_stream_unit - streaming 3x3 / 5x5 / 7x7 gaussian blur
// Raster pixels in, truncated weighted window averages for interior pixels out.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while s_ready is high, which drops when
// the output stalls, and raises m_valid once the pixel completing its window
// has passed the pipeline; the rate is set by the line memory, which serves
// one column read and one column write per pixel. Border pixels and frames
// smaller than the window give no item. A write to the kernel, width or height
// register restarts the frame counters. Line memory contents need no clearing
// after reset, as a result only uses pixels written earlier in the same frame.
`default_nettype none

module gaussian_blur_stream_unit (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire  [1:0]                  cfg_index,
    input  wire  [12:0]                 cfg_wdata,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [7:0]                  s_pixel,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [7:0]                  m_blurred,
    output logic [gbs_pkg::COL_W-1:0]   m_out_x,
    output logic [gbs_pkg::ROW_W-1:0]   m_out_y,
    output logic                        m_frame_last
);
    import gbs_pkg::*;

    // configuration
    logic [1:0]       ksel_reg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [1:0] sel;
    logic [2:0] radius;
    logic       s_fire;
    logic [6:1] v_reg;
    logic [6:1] rdy;

    assign sel    = (ksel_reg > KSEL_7X7) ? KSEL_7X7 : ksel_reg;
    assign radius = {1'b0, sel} + 3'd1;
    assign s_fire = s_valid && s_ready;

    // stall chain, each stage fills when empty or when its successor moves
    always_comb begin
        rdy[6] = !v_reg[6] || m_ready;
        for (int k = 5; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign s_ready = rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksel_reg   <= KSEL_3X3;
            width_reg  <= WID_W'(640);
            height_reg <= HGT_W'(480);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KERNEL: ksel_reg <= cfg_wdata[1:0];
                CFG_WIDTH: begin
                    if (cfg_wdata[11:0] == 12'd0) begin
                        width_reg <= WID_W'(1);
                    end else if (cfg_wdata[11:0] > 12'(MAX_WIDTH)) begin
                        width_reg <= WID_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= cfg_wdata[11:0];
                    end
                end
                CFG_HEIGHT: begin
                    if (cfg_wdata == 13'd0) begin
                        height_reg <= HGT_W'(1);
                    end else if (cfg_wdata > 13'(MAX_HEIGHT)) begin
                        height_reg <= HGT_W'(MAX_HEIGHT);
                    end else begin
                        height_reg <= cfg_wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    // frame position counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en && (cfg_index inside {CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT})) begin
            col_next = '0;
            row_next = '0;
        end else if (s_fire) begin
            if ({1'b0, col_reg} + WID_W'(1) >= width_reg) begin
                col_next = '0;
                if ({1'b0, row_reg} + HGT_W'(1) >= height_reg) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage one: line memory read in flight, item position captured
    pix_t             px1_reg;
    logic [COL_W-1:0] addr1_reg;
    logic             emit1_reg;
    meta_t            meta1_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            px1_reg   <= s_pixel;
            addr1_reg <= col_reg;
            emit1_reg <= (col_reg >= COL_W'({radius, 1'b0}))
                      && (row_reg >= ROW_W'({radius, 1'b0}));
            meta1_reg.x    <= col_reg - COL_W'(radius);
            meta1_reg.y    <= row_reg - ROW_W'(radius);
            meta1_reg.last <= ({1'b0, col_reg} + WID_W'(1) == width_reg)
                           && ({1'b0, row_reg} + HGT_W'(1) == height_reg);
        end
    end

    line_ctl_t            lctl;
    logic [LINE_BITS-1:0] lines;
    logic                 adv1;

    assign adv1         = v_reg[1] && rdy[2];
    assign lctl.rd_en   = s_fire;
    assign lctl.rd_addr = col_reg;
    assign lctl.wr_en   = adv1;
    assign lctl.wr_addr = addr1_reg;

    gbs_line_buf u_line_buf (
        .aclk     (aclk),
        .ctl      (lctl),
        .wr_pixel (px1_reg),
        .rd_lines (lines)
    );

    // window shift: oldest line on top, incoming pixel at the bottom
    pix_t win_reg  [WIN][WIN];
    pix_t win_next [WIN][WIN];
    pix_t column   [WIN];

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            column[i] = lines[8*(LINES-1-i) +: 8];
        end
        column[WIN-1] = px1_reg;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) begin
                win_next[i][j] = win_reg[i][j+1];
            end
            win_next[i][WIN-1] = column[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            win_reg <= win_next;
        end
    end

    // stage two: weighted products
    logic [15:0] prod2_reg [WIN][WIN];
    meta_t       meta2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    prod2_reg[i][j] <= 16'(KERN[sel][i][j]) * 16'(win_next[i][j]);
                end
            end
            meta2_reg <= meta1_reg;
        end
    end

    // stage three: row sums
    logic [SUM_W-1:0] rowsum3_reg [WIN];
    logic [SUM_W-1:0] rowsum      [WIN];
    meta_t            meta3_reg;

    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            rowsum[i] = '0;
            for (int j = 0; j < WIN; j++) begin
                rowsum[i] = rowsum[i] + SUM_W'(prod2_reg[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            rowsum3_reg <= rowsum;
            meta3_reg   <= meta2_reg;
        end
    end

    // stage four: window total
    logic [SUM_W-1:0] total4_reg;
    logic [SUM_W-1:0] total;
    meta_t            meta4_reg;

    always_comb begin
        total = '0;
        for (int i = 0; i < WIN; i++) begin
            total = total + rowsum3_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            total4_reg <= total;
            meta4_reg  <= meta3_reg;
        end
    end

    // stage five: divide by the weight total through its reciprocal
    logic [MUL_W-1:0] mul5_reg;
    meta_t            meta5_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            mul5_reg  <= MUL_W'(total4_reg) * MUL_W'(recip(sel));
            meta5_reg <= meta4_reg;
        end
    end

    // stage six: output register
    pix_t  blur6_reg;
    meta_t meta6_reg;

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            blur6_reg <= mul5_reg[RECIP_S +: 8];
            meta6_reg <= meta5_reg;
        end
    end

    // stage valids; items without a result drop out after the window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) v_reg[1] <= s_fire;
            if (rdy[2]) v_reg[2] <= v_reg[1] && emit1_reg;
            for (int k = 3; k <= 6; k++) begin
                if (rdy[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign m_valid      = v_reg[6];
    assign m_blurred    = blur6_reg;
    assign m_out_x      = meta6_reg.x;
    assign m_out_y      = meta6_reg.y;
    assign m_frame_last = meta6_reg.last;

    // counters stay inside the configured frame
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < width_reg)
        else $error("column counter outside frame");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < height_reg)
        else $error("row counter outside frame");

    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && v_reg == '0)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: rtl/gbs_line_buf.sv
// ----------------------------------------------------------------------------
// gbs_line_buf - line buffer memory for the blur window
// Holds the last six rows, one column per entry; reads a column and writes
// it back shifted by one line with the new pixel on line zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_line_buf (
    input  wire                        aclk,
    input  wire  gbs_pkg::line_ctl_t   ctl,
    input  wire  [7:0]                 wr_pixel,
    output logic [gbs_pkg::LINE_BITS-1:0] rd_lines
);
    import gbs_pkg::*;

    logic [LINE_BITS-1:0] mem [MAX_WIDTH];
    logic [LINE_BITS-1:0] rd_data_reg;

    // synchronous read, held while no new read is issued
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    // write back: lines move down by one, newest pixel on line zero
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= {rd_data_reg[LINE_BITS-9:0], wr_pixel};
        end
    end

    assign rd_lines = rd_data_reg;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the gaussian blur stream unit
// Feeds raster frames under several kernel and frame-size settings, predicts
// every blurred pixel with its own window and line store, and checks each
// result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gbs_pkg::*;

    typedef struct {
        logic [7:0]       blurred;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             last;
    } blur_item_t;

    // gaussian weights, kernel in the top-left corner of the 7x7 array
    localparam int WEIGHT [3][7][7] = '{
        '{ '{1,2,1,0,0,0,0}, '{2,4,2,0,0,0,0}, '{1,2,1,0,0,0,0},
           '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0},
           '{0,0,0,0,0,0,0} },
        '{ '{1,4,7,4,1,0,0}, '{4,16,26,16,4,0,0}, '{7,26,41,26,7,0,0},
           '{4,16,26,16,4,0,0}, '{1,4,7,4,1,0,0}, '{0,0,0,0,0,0,0},
           '{0,0,0,0,0,0,0} },
        '{ '{0,0,1,2,1,0,0}, '{0,3,13,22,13,3,0}, '{1,13,59,97,59,13,1},
           '{2,22,97,159,97,22,2}, '{1,13,59,97,59,13,1},
           '{0,3,13,22,13,3,0}, '{0,0,1,2,1,0,0} }
    };
    localparam int WEIGHT_TOTAL [3] = '{16, 273, 1003};

    // pixels sent in the randomised part of the run
    localparam int RANDOM_ITEMS = 870;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [12:0]       cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_pixel;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_blurred;
    logic [COL_W-1:0]  m_out_x;
    logic [ROW_W-1:0]  m_out_y;
    logic              m_frame_last;

    // predictor state
    logic [7:0]        line_mem [LINES][MAX_WIDTH];
    logic [7:0]        window [WIN][WIN];
    int unsigned       col_pos, row_pos;
    int unsigned       ksel, frame_w, frame_h;

    logic [7:0]        pending_pixels [$];
    blur_item_t        expected_blur [$];
    int                error_count;
    bit                pixel_taken;
    int                send_gap, recv_hold;
    bit                quiet_send, quiet_recv, long_stall_req;
    int                random_items;

    gaussian_blur_stream_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blurred    (m_blurred),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_frame_last (m_frame_last)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // window update and blur prediction for one accepted pixel
    function automatic void predict_blur(logic [7:0] px);
        logic [7:0]  column [WIN];
        int unsigned sel, rad, base, acc, c;
        blur_item_t  exp_item;
        sel = (ksel > 2) ? 2 : ksel;
        rad = sel + 1;
        c = col_pos % MAX_WIDTH;
        for (int i = 0; i < LINES; i++) column[i] = line_mem[LINES-1-i][c];
        column[WIN-1] = px;
        for (int i = LINES - 1; i > 0; i--) line_mem[i][c] = line_mem[i-1][c];
        line_mem[0][c] = px;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) window[i][j] = window[i][j+1];
            window[i][WIN-1] = column[i];
        end
        if (col_pos >= 2 * rad && row_pos >= 2 * rad) begin
            base = LINES - 2 * rad;
            acc = 0;
            for (int i = 0; i <= 2 * rad; i++)
                for (int j = 0; j <= 2 * rad; j++)
                    acc += WEIGHT[sel][i][j] * window[base+i][base+j];
            exp_item.blurred = 8'(acc / WEIGHT_TOTAL[sel]);
            exp_item.x = COL_W'(col_pos - rad);
            exp_item.y = ROW_W'(row_pos - rad);
            exp_item.last = (col_pos + 1 == frame_w && row_pos + 1 == frame_h);
            expected_blur.insert(expected_blur.size(), exp_item);
        end
        if (col_pos + 1 >= frame_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= frame_h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // input acceptance, register writes and result checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            col_pos = 0;
            row_pos = 0;
            ksel = 32'(KSEL_3X3);
            frame_w = 640;
            frame_h = 480;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KERNEL: ksel = 32'(cfg_wdata[1:0]);
                    CFG_WIDTH:  frame_w = clamp_dim(32'(cfg_wdata[11:0]), MAX_WIDTH);
                    CFG_HEIGHT: frame_h = clamp_dim(32'(cfg_wdata[12:0]), MAX_HEIGHT);
                    default: ;
                endcase
                col_pos = 0;
                row_pos = 0;
            end
            if (s_valid && s_ready) begin
                predict_blur(s_pixel);
                pixel_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_blur.size() == 0) begin
                    $display("%0t: unexpected item blurred=%0d x=%0d y=%0d last=%0d",
                             $time, m_blurred, m_out_x, m_out_y, m_frame_last);
                    error_count++;
                end else begin
                    blur_item_t e;
                    e = expected_blur.pop_front();
                    if (m_blurred !== e.blurred) begin
                        $display("%0t: blurred expected %0d actual %0d",
                                 $time, e.blurred, m_blurred);
                        error_count++;
                    end
                    if (m_out_x !== e.x) begin
                        $display("%0t: out_x expected %0d actual %0d", $time, e.x, m_out_x);
                        error_count++;
                    end
                    if (m_out_y !== e.y) begin
                        $display("%0t: out_y expected %0d actual %0d", $time, e.y, m_out_y);
                        error_count++;
                    end
                    if (m_frame_last !== e.last) begin
                        $display("%0t: frame_last expected %0d actual %0d",
                                 $time, e.last, m_frame_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || pixel_taken)) begin
            pixel_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                s_pixel <= pending_pixels.pop_front();
                s_valid <= 1'b1;
                send_gap = pick_gap(quiet_send);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                recv_hold = 400;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (pick_gap(quiet_recv) > 0) begin
                recv_hold = pick_gap(1'b0);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        wait (pending_pixels.size() == 0 && !s_valid);
        wait (expected_blur.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(int k, int w, int h);
        wait_idle();
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
        write_reg(CFG_KERNEL, 13'(k));
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
    endtask

    task automatic push_flat(int n, logic [7:0] v);
        repeat (n) pending_pixels.insert(pending_pixels.size(), v);
    endtask

    task automatic push_random(int n);
        repeat (n) pending_pixels.insert(pending_pixels.size(),
                                         8'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial begin
        int k, w, h, n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_KERNEL;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        m_ready = 1'b0;
        error_count = 0;
        pixel_taken = 1'b0;
        send_gap = 0;
        recv_hold = 0;
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        long_stall_req = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // smallest frames with extreme pixel values for each kernel
        set_frame(KSEL_3X3, 3, 3);
        push_flat(9, 8'd255);
        push_flat(9, 8'd0);
        set_frame(KSEL_5X5, 5, 5);
        push_flat(25, 8'd255);
        // select three behaves as 7x7
        set_frame(3, 7, 7);
        push_flat(49, 8'd255);
        // zero sizes act as one pixel, so nothing comes out
        set_frame(KSEL_3X3, 0, 0);
        push_random(5);
        // frame narrower than the window
        set_frame(KSEL_7X7, 6, 10);
        push_random(60);
        // oversize width and height saturate
        set_frame(KSEL_7X7, 4095, 8191);
        push_random(20);

        // first random frame long enough to back up under a held receiver
        set_frame(KSEL_5X5, 16, 16);
        quiet_send = 1'b1;
        long_stall_req = 1'b1;
        push_random(256);
        random_items = 256;
        while (random_items < RANDOM_ITEMS) begin
            k = $urandom_range(0, 3);
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 20);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            if (n > 300) n = 300;
            if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
            set_frame(k, w, h);
            push_random(n);
            random_items += n;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_blur.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
